// ===== hw/rtl/hufd_pkg.sv =====
package hufd_pkg;

  // Tree geometry
  localparam int SYM_CNT      = 256;
  localparam int NODE_ENTRIES = SYM_CNT - 1;
  localparam int IDX_W        = 9;
  localparam int SLOT_W       = 8;
  localparam int SYM_W        = 8;
  localparam int ENTRY_W      = 2 * IDX_W;
  localparam int CNT_W        = 32;
  localparam int BIT_CNT_W    = 3;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam idx_t ROOT_IDX = 9'd510;
  localparam idx_t NONE_IDX = 9'd511;

  // Item actions
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_SYM_EXP  = 1'b0;
  localparam logic REG_BYTE_EXP = 1'b1;

  // Walker to output stage, one record per walker cycle
  typedef struct packed {
    logic leaf;
    logic close;
    logic fin;
    sym_t sym;
  } emit_t;

endpackage

// ===== hw/rtl/hufd_ram.sv =====
module hufd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 255
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/hufd_out.sv =====
module hufd_out (
  input  logic           clk,
  input  logic           rst_n,
  input  hufd_pkg::emit_t ev,
  output logic           ready,
  output logic           out_valid,
  input  logic           out_stall,
  output hufd_pkg::sym_t out_symbol,
  output logic           out_last,
  output logic           out_finished
);
  import hufd_pkg::*;

  // Pending symbol: last is known only when the next leaf or the byte end shows up
  logic p_vld_r, p_vld_nxt;
  logic p_last_r, p_last_nxt;
  logic p_fin_r, p_fin_nxt;
  sym_t p_sym_r, p_sym_nxt;

  logic o_vld_r, o_vld_nxt;
  logic o_last_r, o_last_nxt;
  logic o_fin_r, o_fin_nxt;
  sym_t o_sym_r, o_sym_nxt;

  logic o_free;
  logic move;

  assign o_free = !o_vld_r || !out_stall;
  assign ready  = !p_vld_r || o_free;
  assign move   = p_vld_r && o_free && (p_last_r || ev.leaf);

  always_comb begin
    p_vld_nxt  = p_vld_r;
    p_last_nxt = p_last_r;
    p_fin_nxt  = p_fin_r;
    p_sym_nxt  = p_sym_r;
    o_vld_nxt  = o_vld_r;
    o_last_nxt = o_last_r;
    o_fin_nxt  = o_fin_r;
    o_sym_nxt  = o_sym_r;

    // Advance pending into the output register
    if (move) begin
      o_vld_nxt  = 1'b1;
      o_last_nxt = p_last_r;
      o_fin_nxt  = p_fin_r;
      o_sym_nxt  = p_sym_r;
      p_vld_nxt  = 1'b0;
    end else if (o_free) begin
      o_vld_nxt = 1'b0;
    end

    // Capture a new leaf, or close the pending one at the end of its byte
    if (ev.leaf) begin
      p_vld_nxt  = 1'b1;
      p_last_nxt = ev.close;
      p_fin_nxt  = ev.fin;
      p_sym_nxt  = ev.sym;
    end else if (ev.close && p_vld_r) begin
      p_last_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      p_vld_r <= p_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
    p_last_r <= p_last_nxt;
    p_fin_r  <= p_fin_nxt;
    p_sym_r  <= p_sym_nxt;
    o_last_r <= o_last_nxt;
    o_fin_r  <= o_fin_nxt;
    o_sym_r  <= o_sym_nxt;
  end

  assign out_valid    = o_vld_r;
  assign out_symbol   = o_sym_r;
  assign out_last     = o_last_r;
  assign out_finished = o_fin_r;

  // Walker never pushes a leaf over a pending symbol that cannot move
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (ev.leaf && p_vld_r) |-> o_free)
    else $error("pending symbol overrun");

  // A move always shows up on the output
  a_move_shows: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid)
    else $error("moved symbol not presented");

  // A closed pending symbol leaves once the output is free
  a_closed_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && p_last_r && o_free && !ev.leaf) |=> !p_vld_r)
    else $error("closed symbol stuck");

endmodule

// ===== hw/rtl/hufd_walk.sv =====
module hufd_walk (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_action,
  input  hufd_pkg::slot_t in_node_slot,
  input  hufd_pkg::idx_t  in_left_child,
  input  hufd_pkg::idx_t  in_right_child,
  input  hufd_pkg::sym_t  in_code_byte,
  input  hufd_pkg::cnt_t  sym_exp,
  input  hufd_pkg::cnt_t  byte_exp,
  input  logic            out_ready,
  output hufd_pkg::emit_t ev
);
  import hufd_pkg::*;

  logic                 busy_r, busy_nxt;
  sym_t                 byte_r, byte_nxt;
  logic [BIT_CNT_W-1:0] bcnt_r, bcnt_nxt;
  idx_t                 node_r, node_nxt;
  logic                 fwd_r, fwd_nxt;
  entry_t               fwd_dat_r, fwd_dat_nxt;
  cnt_t                 sym_cnt_r, sym_cnt_nxt;
  cnt_t                 byte_cnt_r, byte_cnt_nxt;
  logic                 stopped_r, stopped_nxt;

  entry_t ram_q;
  entry_t kids;
  idx_t   child;
  slot_t  rd_addr;
  logic   we;
  entry_t wdata;
  logic   halt;
  logic   leaf_raw;
  logic   fin;
  logic   bend;
  logic   go;
  logic   acc;
  cnt_t   sym_inc;
  cnt_t   byte_inc;
  idx_t   node_off;

  // Tree node store
  hufd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NODE_ENTRIES)
  ) u_tree (
    .clk  (clk),
    .we   (we),
    .waddr(in_node_slot),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // Children of the current node, with write forwarding
  always_comb begin
    if (node_r == NONE_IDX) begin
      kids = '0;
    end else if (fwd_r) begin
      kids = fwd_dat_r;
    end else begin
      kids = ram_q;
    end
  end

  assign child    = byte_r[SYM_W-1] ? kids[ENTRY_W-1:IDX_W] : kids[IDX_W-1:0];
  assign sym_inc  = sym_cnt_r + cnt_t'(1);
  assign byte_inc = byte_cnt_r + cnt_t'(1);
  assign halt     = busy_r && (bcnt_r == '0) && (stopped_r || (byte_cnt_r >= byte_exp));
  assign leaf_raw = busy_r && !halt && (child < idx_t'(SYM_CNT));
  assign fin      = leaf_raw && (sym_exp != '0) && (sym_inc == sym_exp);
  assign bend     = busy_r && (halt || (bcnt_r == '1) || fin);
  assign go       = busy_r && !(leaf_raw && !out_ready);
  assign in_stall = busy_r && !(go && bend);
  assign acc      = in_valid && !in_stall;

  assign ev.leaf  = leaf_raw && go;
  assign ev.close = bend && go && !halt;
  assign ev.fin   = fin;
  assign ev.sym   = child[SYM_W-1:0];

  // Node loads
  assign we    = acc && (in_action == ACT_LOAD) && (in_node_slot < slot_t'(NODE_ENTRIES));
  assign wdata = {in_right_child, in_left_child};

  always_comb begin
    busy_nxt     = busy_r;
    byte_nxt     = byte_r;
    bcnt_nxt     = bcnt_r;
    node_nxt     = node_r;
    sym_cnt_nxt  = sym_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    stopped_nxt  = stopped_r;

    // Step one code bit
    if (go) begin
      byte_nxt = {byte_r[SYM_W-2:0], 1'b0};
      bcnt_nxt = bcnt_r + 1'b1;
      if (leaf_raw) begin
        node_nxt    = ROOT_IDX;
        sym_cnt_nxt = sym_inc;
      end else if (!halt) begin
        node_nxt = child;
      end
      if (bend) begin
        busy_nxt = 1'b0;
        if (halt || fin) begin
          stopped_nxt = 1'b1;
        end else begin
          byte_cnt_nxt = byte_inc;
          stopped_nxt  = stopped_r || (byte_inc >= byte_exp);
        end
      end
    end

    // Take a new code byte
    if (acc && (in_action == ACT_DECODE)) begin
      busy_nxt = 1'b1;
      byte_nxt = in_code_byte;
      bcnt_nxt = '0;
    end
  end

  // Read address for the node walked next cycle
  assign node_off = node_nxt - idx_t'(SYM_CNT);
  assign rd_addr  = (node_nxt == NONE_IDX) ? '0 : node_off[SLOT_W-1:0];
  assign fwd_nxt     = we && (in_node_slot == rd_addr);
  assign fwd_dat_nxt = wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      bcnt_r     <= '0;
      node_r     <= ROOT_IDX;
      fwd_r      <= 1'b0;
      sym_cnt_r  <= '0;
      byte_cnt_r <= '0;
      stopped_r  <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      bcnt_r     <= bcnt_nxt;
      node_r     <= node_nxt;
      fwd_r      <= fwd_nxt;
      sym_cnt_r  <= sym_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      stopped_r  <= stopped_nxt;
    end
    byte_r    <= byte_nxt;
    fwd_dat_r <= fwd_dat_nxt;
  end

  // Stop is sticky
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stop flag cleared");

  // A reached leaf returns the walk to the root
  a_leaf_root: assert property (@(posedge clk) disable iff (!rst_n)
    (go && leaf_raw) |=> (node_r == ROOT_IDX))
    else $error("walk not back at root after leaf");

  // Walker goes idle at the byte end unless a new code byte is taken
  a_byte_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (go && bend && !(acc && in_action == ACT_DECODE)) |=> !busy_r)
    else $error("walker busy after byte end");

  // No symbol is produced once stopped at the start of a byte
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halt |-> !ev.leaf)
    else $error("symbol after stop");

endmodule

// ===== hw/rtl/huffman_tree_walk_decoder_top.sv =====
// Output: a symbol is held until the next leaf or the end of its byte sets last.
// Throughput: one code bit per cycle while the output is not stalled, set by the dependent
//   read of the tree memory for each bit; one node load per cycle while no byte is walking.
// Reset: rst_n is synchronous, active low; clears walk position, counters, stop flag,
//   registers and output valid; the tree memory is not cleared.
module huffman_tree_walk_decoder_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_action,
  input  hufd_pkg::slot_t in_node_slot,
  input  hufd_pkg::idx_t  in_left_child,
  input  hufd_pkg::idx_t  in_right_child,
  input  hufd_pkg::sym_t  in_code_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output hufd_pkg::sym_t  out_symbol,
  output logic            out_last,
  output logic            out_finished,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import hufd_pkg::*;

  cnt_t  sym_exp_r, sym_exp_nxt;
  cnt_t  byte_exp_r, byte_exp_nxt;
  logic  cfg_wr;
  logic  out_ready;
  emit_t ev;

  // Register write, decoded on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    sym_exp_nxt  = sym_exp_r;
    byte_exp_nxt = byte_exp_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_SYM_EXP:  sym_exp_nxt  = pwdata;
        REG_BYTE_EXP: byte_exp_nxt = pwdata;
        default:      sym_exp_nxt  = sym_exp_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SYM_EXP:  prdata = sym_exp_r;
      REG_BYTE_EXP: prdata = byte_exp_r;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_exp_r  <= '0;
      byte_exp_r <= '0;
    end else begin
      sym_exp_r  <= sym_exp_nxt;
      byte_exp_r <= byte_exp_nxt;
    end
  end

  hufd_walk u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_node_slot  (in_node_slot),
    .in_left_child (in_left_child),
    .in_right_child(in_right_child),
    .in_code_byte  (in_code_byte),
    .sym_exp       (sym_exp_r),
    .byte_exp      (byte_exp_r),
    .out_ready     (out_ready),
    .ev            (ev)
  );

  hufd_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev          (ev),
    .ready       (out_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_symbol  (out_symbol),
    .out_last    (out_last),
    .out_finished(out_finished)
  );

endmodule
